// ===== design/tamd_pkg.sv =====
// ----------------------------------------------------------------------------
// tamd_pkg
// Types, codes and the decision tree of the acknowledgment decider.
// ----------------------------------------------------------------------------
package tamd_pkg;

  localparam int NodeCount     = 9;
  localparam int TreePosW      = 4;
  localparam int FlagW         = 6;
  localparam int AddrW         = 16;
  localparam int FailW         = 8;
  localparam int FlagPositions = 64;  // positions at or above are ignored

  // input operations
  localparam logic [1:0] OP_ACK   = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  // membership bit operations
  localparam logic [1:0] BIT_KEEP = 2'd0;
  localparam logic [1:0] BIT_SET  = 2'd1;
  localparam logic [1:0] BIT_CLR  = 2'd2;

  // config register indexes
  localparam logic CFG_OWN_POS  = 1'b0;
  localparam logic CFG_MAX_FAIL = 1'b1;

  typedef enum logic [2:0] {
    KIND_DECIDE = 3'd0,
    KIND_TENT   = 3'd1,
    KIND_BACK   = 3'd2,
    KIND_POS    = 3'd3,
    KIND_NEG    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_FT   = 3'd1,
    ACT_T    = 3'd2,
    ACT_FF   = 3'd3,
    ACT_FTT  = 3'd4,
    ACT_FTFT = 3'd5,
    ACT_FTFF = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ACK_WAIT = 2'd0,
    ACK_NEG  = 2'd1,
    ACK_TENT = 2'd2,
    ACK_POS  = 2'd3
  } ack_e;

  typedef struct packed {
    kind_e                kind;
    act_e                 action;
    logic [TreePosW-1:0]  next0;
    logic [TreePosW-1:0]  next1;
  } node_t;

  // walk outcome handed to the action decoder
  typedef struct packed {
    ack_e                 res;
    act_e                 action;
    logic [TreePosW-1:0]  pos;
  } walk_t;

  // state changes asked for by the action decoder
  typedef struct packed {
    logic                 store_succ;
    logic [FailW-1:0]     fail_d;
  } upd_t;

  // one result beat
  typedef struct packed {
    ack_e                 ack_result;
    act_e                 action_code;
    logic [1:0]           own_bit_op;
    logic [1:0]           sender_bit_op;
    logic [1:0]           successor_bit_op;
    logic [FlagW-1:0]     successor_pos;
    logic                 status_write;
    logic [AddrW-1:0]     status_addr;
    logic                 status_correct;
    logic                 membership_error;
    logic                 membership_loss;
  } res_t;

  function automatic node_t tree_node(input logic [TreePosW-1:0] idx);
    node_t n;
    case (idx)
      4'd0:    n = '{KIND_DECIDE, ACT_NONE, 4'd1, 4'd2};
      4'd1:    n = '{KIND_POS,    ACT_T,    4'd0, 4'd0};
      4'd2:    n = '{KIND_DECIDE, ACT_NONE, 4'd3, 4'd4};
      4'd3:    n = '{KIND_TENT,   ACT_FT,   4'd5, 4'd6};
      4'd4:    n = '{KIND_BACK,   ACT_FF,   4'd0, 4'd0};
      4'd5:    n = '{KIND_POS,    ACT_FTT,  4'd0, 4'd0};
      4'd6:    n = '{KIND_DECIDE, ACT_NONE, 4'd7, 4'd8};
      4'd7:    n = '{KIND_NEG,    ACT_FTFT, 4'd0, 4'd0};
      4'd8:    n = '{KIND_BACK,   ACT_FTFF, 4'd3, 4'd3};
      default: n = '{KIND_DECIDE, ACT_NONE, 4'd1, 4'd2};
    endcase
    return n;
  endfunction

endpackage

// ===== design/tamd_walk.sv =====
// ----------------------------------------------------------------------------
// tamd_walk
// Walks one channel's tree position by one or two steps.
// ----------------------------------------------------------------------------
module tamd_walk (
  input  logic [tamd_pkg::TreePosW-1:0] pos_i,
  input  logic                          check_a_i,
  input  logic                          check_b_i,
  output tamd_pkg::walk_t               walk_o
);
  import tamd_pkg::*;

  typedef struct packed {
    logic                 cont;
    ack_e                 res;
    act_e                 action;
    logic [TreePosW-1:0]  pos;
  } step_t;

  function automatic step_t step(input logic [TreePosW-1:0] pos, input logic br);
    logic [TreePosW-1:0] p;
    logic [TreePosW-1:0] nxt;
    node_t               cur;
    node_t               n;
    step_t               s;
    p   = (pos >= TreePosW'(NodeCount)) ? '0 : pos;  // off-tree reads as root
    cur = tree_node(p);
    nxt = br ? cur.next1 : cur.next0;
    n   = tree_node(nxt);
    s.cont   = 1'b0;
    s.res    = ACK_WAIT;
    s.action = n.action;
    s.pos    = nxt;
    case (n.kind)
      KIND_TENT: s.res = ACK_TENT;
      KIND_BACK: s.pos = n.next0;
      KIND_POS: begin
        s.res = ACK_POS;
        s.pos = '0;
      end
      KIND_NEG: begin
        s.res = ACK_NEG;
        s.pos = '0;
      end
      default:   s.cont = 1'b1;
    endcase
    return s;
  endfunction

  step_t s1, s2;

  always_comb begin
    s1 = step(pos_i, check_a_i);
    s2 = step(s1.pos, check_b_i);
    if (!s1.cont) begin
      walk_o = '{s1.res, s1.action, s1.pos};
    end else if (!s2.cont) begin
      walk_o = '{s2.res, s2.action, s2.pos};
    end else begin
      walk_o = '{ACK_WAIT, ACT_NONE, s2.pos};
    end
  end

endmodule

// ===== design/tamd_act.sv =====
// ----------------------------------------------------------------------------
// tamd_act
// Decodes the processor action into result fields and state updates.
// ----------------------------------------------------------------------------
module tamd_act (
  input  tamd_pkg::walk_t                walk_i,
  input  logic [tamd_pkg::FlagW-1:0]     own_pos_i,
  input  logic [tamd_pkg::FailW-1:0]     max_fail_i,
  input  logic [tamd_pkg::FlagW-1:0]     sender_pos_i,
  input  logic [tamd_pkg::FlagW-1:0]     succ_flag_i,
  input  logic [tamd_pkg::AddrW-1:0]     succ_addr_i,
  input  logic [tamd_pkg::FailW-1:0]     fail_i,
  output tamd_pkg::res_t                 res_o,
  output tamd_pkg::upd_t                 upd_o
);
  import tamd_pkg::*;

  function automatic logic [1:0] bit_op(input logic [1:0] op, input logic [FlagW-1:0] pos);
    return ({1'b0, pos} < (FlagW+1)'(FlagPositions)) ? op : BIT_KEEP;
  endfunction

  logic [FailW-1:0] fail_inc;

  assign fail_inc = (fail_i == {FailW{1'b1}}) ? fail_i : fail_i + FailW'(1);

  always_comb begin
    res_o             = '0;
    res_o.ack_result  = walk_i.res;
    res_o.action_code = walk_i.action;
    upd_o.store_succ  = 1'b0;
    upd_o.fail_d      = fail_i;
    case (walk_i.action)
      ACT_FT: upd_o.store_succ = 1'b1;
      ACT_T: begin
        res_o.own_bit_op    = bit_op(BIT_SET, own_pos_i);
        res_o.sender_bit_op = bit_op(BIT_SET, sender_pos_i);
        upd_o.fail_d        = '0;
      end
      ACT_FF: begin
        res_o.own_bit_op    = bit_op(BIT_SET, own_pos_i);
        res_o.sender_bit_op = bit_op(BIT_CLR, sender_pos_i);
      end
      ACT_FTT: begin
        res_o.own_bit_op       = bit_op(BIT_SET, own_pos_i);
        res_o.sender_bit_op    = bit_op(BIT_SET, sender_pos_i);
        res_o.successor_bit_op = bit_op(BIT_CLR, succ_flag_i);
        res_o.status_write     = 1'b1;
        res_o.status_addr      = succ_addr_i;
        upd_o.fail_d           = '0;
      end
      ACT_FTFT: begin
        res_o.own_bit_op       = bit_op(BIT_CLR, own_pos_i);
        res_o.sender_bit_op    = bit_op(BIT_SET, sender_pos_i);
        res_o.successor_bit_op = bit_op(BIT_SET, succ_flag_i);
        res_o.status_write     = 1'b1;
        res_o.status_addr      = succ_addr_i;
        res_o.status_correct   = 1'b1;
        res_o.membership_error = (fail_inc == max_fail_i);
        res_o.membership_loss  = (fail_inc != max_fail_i);
        upd_o.fail_d           = fail_inc;
      end
      ACT_FTFF: begin
        res_o.own_bit_op       = bit_op(BIT_SET, own_pos_i);
        res_o.sender_bit_op    = bit_op(BIT_CLR, sender_pos_i);
        res_o.successor_bit_op = bit_op(BIT_CLR, succ_flag_i);
      end
      default: ;
    endcase
    res_o.successor_pos = (res_o.successor_bit_op != BIT_KEEP) ? succ_flag_i : '0;
  end

endmodule

// ===== design/tdma_ack_membership_decider.sv =====
// ----------------------------------------------------------------------------
// tdma_ack_membership_decider
// Acknowledgment and membership decision for a time-triggered bus sender.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command beat: tuser holds operation and channel,
//   tdata holds check results and the slot sender's flag position and
//   message address. Every beat yields exactly one m_axis result beat;
//   init, merge and unknown operations return an all-zero result.
//   The cfg channel writes own_flag_pos (index 0) or max_fail_count (index 1);
//   it is always ready. The user must write it only while idle (not checked).
// Timing:
//   A beat lands in the input register on acceptance; the tree walk and
//   action decode are combinational from it, and the result register is
//   loaded from them when the result register is free to take it.
//   One beat per cycle is sustained while m_axis_tready is high: the input
//   and result registers form a two-entry pipeline, and the per-channel state updates as the result loads.
// Reset:
//   Both tree positions go to the root; successor, fail count and config
//   registers clear. No beats are held.
// Stall:
//   While m_axis_tready is low the result holds; one more beat is
//   taken into the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module tdma_ack_membership_decider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] check_a, [1] check_b, [7:2] sender_flag_pos, [23:8] sender_msg_addr
  input  logic [23:0] s_axis_tdata,
  // [1:0] operation, [2] channel
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] action_code, [4:3] own_bit_op, [6:5] sender_bit_op,
  // [8:7] successor_bit_op, [14:9] successor_pos, [15] status_write,
  // [31:16] status_addr, [32] status_correct, [33] membership_error,
  // [34] membership_loss, [39:35] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] ack_result
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tamd_pkg::*;

  // input register
  logic                 in_valid_q;
  logic [1:0]           in_op_q;
  logic                 in_ca_q, in_cb_q, in_ch_q;
  logic [FlagW-1:0]     in_spos_q;
  logic [AddrW-1:0]     in_saddr_q;

  // block state
  logic [TreePosW-1:0]  pos_q [2];
  logic [FlagW-1:0]     succ_flag_q;
  logic [AddrW-1:0]     succ_addr_q;
  logic [FailW-1:0]     fail_q;
  logic [FlagW-1:0]     own_q;
  logic [FailW-1:0]     max_q;

  // result register
  logic                 out_valid_q;
  res_t                 out_q;

  logic                 out_free, fire, s_fire;
  walk_t                walk_raw, walk_sel;
  res_t                 res;
  upd_t                 upd;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tamd_walk u_walk (
    .pos_i     (pos_q[in_ch_q]),
    .check_a_i (in_ca_q),
    .check_b_i (in_cb_q),
    .walk_o    (walk_raw)
  );

  // non-acknowledge beats give an all-zero result and leave counters alone
  assign walk_sel = (in_op_q == OP_ACK) ? walk_raw : walk_t'{ACK_WAIT, ACT_NONE, '0};

  tamd_act u_act (
    .walk_i       (walk_sel),
    .own_pos_i    (own_q),
    .max_fail_i   (max_q),
    .sender_pos_i (in_spos_q),
    .succ_flag_i  (succ_flag_q),
    .succ_addr_i  (succ_addr_q),
    .fail_i       (fail_q),
    .res_o        (res),
    .upd_o        (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_op_q    <= s_axis_tuser[1:0];
      in_ch_q    <= s_axis_tuser[2];
      in_ca_q    <= s_axis_tdata[0];
      in_cb_q    <= s_axis_tdata[1];
      in_spos_q  <= s_axis_tdata[7:2];
      in_saddr_q <= s_axis_tdata[23:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      succ_flag_q <= '0;
      succ_addr_q <= '0;
      fail_q      <= '0;
    end else if (fire) begin
      fail_q <= upd.fail_d;
      if (upd.store_succ) begin
        succ_flag_q <= in_spos_q;
        succ_addr_q <= in_saddr_q;
      end
      case (in_op_q)
        OP_ACK:   pos_q[in_ch_q] <= walk_raw.pos;
        OP_INIT: begin
          pos_q[0] <= '0;
          pos_q[1] <= '0;
        end
        OP_MERGE: pos_q[!in_ch_q] <= pos_q[in_ch_q];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      max_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OWN_POS:  own_q <= cfg_data_i[FlagW-1:0];
        CFG_MAX_FAIL: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.ack_result;
  assign m_axis_tdata  = {5'b0,
                          out_q.membership_loss,
                          out_q.membership_error,
                          out_q.status_correct,
                          out_q.status_addr,
                          out_q.status_write,
                          out_q.successor_pos,
                          out_q.successor_bit_op,
                          out_q.sender_bit_op,
                          out_q.own_bit_op,
                          out_q.action_code};

`ifndef NO_ASSERTIONS
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pos_q[0]) && $stable(pos_q[1]) && $stable(fail_q))
    else $error("state changed without a beat");

  a_pos_on_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q[0] < TreePosW'(NodeCount) && pos_q[1] < TreePosW'(NodeCount))
    else $error("tree position off the tree");

  a_final_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_op_q == OP_ACK && (walk_raw.res == ACK_POS || walk_raw.res == ACK_NEG)
    |=> pos_q[$past(in_ch_q)] == '0)
    else $error("final outcome did not return to root");

  a_status_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status_write
    |-> out_q.action_code == ACT_FTT || out_q.action_code == ACT_FTFT)
    else $error("status write from wrong action");
`endif

endmodule
